FILE: sv/vmm_pkg.sv
package vmm_pkg;

  // Element type register layout: bit 0 selects signed, bits 2..1 the size.
  localparam int unsigned TYPE_W = 3;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Mask that keeps the low bits of the configured element size.
  function automatic logic [DATA_W-1:0] type_mask(input logic [TYPE_W-1:0] et);
    logic [DATA_W-1:0] m;
    unique case (et[2:1])
      SIZE_8:  m = 64'h0000_0000_0000_00FF;
      SIZE_16: m = 64'h0000_0000_0000_FFFF;
      SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
      SIZE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Takes the low bits of a raw sample and sign-extends them for signed types.
  function automatic logic [DATA_W-1:0] read_element(input logic [DATA_W-1:0] raw,
                                                    input logic [TYPE_W-1:0] et);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    logic              top;
    m = type_mask(et);
    v = raw & m;
    unique case (et[2:1])
      SIZE_8:  top = raw[7];
      SIZE_16: top = raw[15];
      SIZE_32: top = raw[31];
      SIZE_64: top = raw[63];
      default: top = raw[63];
    endcase
    if (et[0] && top) begin
      v = v | ~m;
    end
    return v;
  endfunction

  // Compares two extended elements as signed or unsigned values.
  function automatic logic elem_less(input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b,
                                     input logic              sgn);
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] bx;
    ax = {a[DATA_W-1] ^ sgn, a[DATA_W-2:0]};
    bx = {b[DATA_W-1] ^ sgn, b[DATA_W-2:0]};
    return ax < bx;
  endfunction

endpackage

FILE: sv/vector_min_max_mean.sv
// Running minimum, maximum and mean over vectors of integers that arrive one
// element per request, read as the type in the element type register. The
// front end takes one element every cycle and updates the accumulators in the
// same cycle; the request that ends a vector hands the totals to a two-entry
// queue, and a bit-serial divider then works out the mean, one quotient bit per
// cycle, and holds the result until it is taken. An empty vector skips the
// division and goes from the idle state straight to done. Elements stream in
// without a pause as long as a queue entry is free; with both entries waiting
// on the divider, the input stalls until it frees one, so vectors shorter than
// the divider time limit the sustained rate to one vector per division.
module vector_min_max_mean import vmm_pkg::*; #(
  parameter int unsigned MAX_LENGTH         = 1024,
  parameter int unsigned MEAN_FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [TYPE_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DATA_W-1:0]        in_sample,
  input  logic                     in_last_element,
  input  logic                     in_empty_vector,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_minimum,
  output logic [DATA_W-1:0]        out_maximum,
  output logic signed [DATA_W-1:0] out_mean_whole,
  output logic [FRAC_W-1:0]        out_mean_fraction,
  output logic [COUNT_W-1:0]       out_element_count,
  output logic                     out_too_long
);

  localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned JOB_W = 3 * DATA_W + 1 + CNT_W;

  logic              push;
  logic              full;
  logic              pop;
  logic              q_valid;
  logic [JOB_W-1:0]  push_data;
  logic [JOB_W-1:0]  pop_data;

  logic [DATA_W-1:0] f_min, f_max, f_sum;
  logic [CNT_W-1:0]  f_count;
  logic              f_ovf;

  logic [DATA_W-1:0] b_min, b_max, b_sum;
  logic [CNT_W-1:0]  b_count;
  logic              b_ovf;

  // Accumulating front end.
  vmm_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_last_element (in_last_element),
    .in_empty_vector (in_empty_vector),
    .job_push        (push),
    .job_full        (full),
    .job_minimum     (f_min),
    .job_maximum     (f_max),
    .job_sum         (f_sum),
    .job_count       (f_count),
    .job_too_long    (f_ovf)
  );

  assign push_data = {f_min, f_max, f_sum, f_ovf, f_count};

  // Finished vectors waiting for the divider.
  vmm_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  assign {b_min, b_max, b_sum, b_ovf, b_count} = pop_data;

  // Mean computation and result register.
  vmm_divider #(
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS),
    .CNT_W              (CNT_W)
  ) u_divider (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (q_valid),
    .job_pop           (pop),
    .job_minimum       (b_min),
    .job_maximum       (b_max),
    .job_sum           (b_sum),
    .job_count         (b_count),
    .job_too_long      (b_ovf),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_minimum       (out_minimum),
    .out_maximum       (out_maximum),
    .out_mean_whole    (out_mean_whole),
    .out_mean_fraction (out_mean_fraction),
    .out_element_count (out_element_count),
    .out_too_long      (out_too_long)
  );

endmodule

FILE: sv/vmm_front.sv
module vmm_front import vmm_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned CNT_W      = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [TYPE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic                 in_last_element,
  input  logic                 in_empty_vector,
  output logic                 job_push,
  input  logic                 job_full,
  output logic [DATA_W-1:0]    job_minimum,
  output logic [DATA_W-1:0]    job_maximum,
  output logic [DATA_W-1:0]    job_sum,
  output logic [CNT_W-1:0]     job_count,
  output logic                 job_too_long
);

  logic [TYPE_W-1:0] type_r;
  logic [DATA_W-1:0] min_r, min_nxt;
  logic [DATA_W-1:0] max_r, max_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;

  logic [DATA_W-1:0] elem;
  logic [DATA_W-1:0] mask;
  logic              accept;
  logic              ends_vector;
  logic              has_room;

  // An element needs no queue space, but keeping the rule simple costs little.
  assign in_ready    = ~job_full;
  assign accept      = in_valid & in_ready;
  assign ends_vector = in_empty_vector | in_last_element;
  assign job_push    = accept & ends_vector;

  assign elem     = read_element(in_sample, type_r);
  assign mask     = type_mask(type_r);
  assign has_room = count_r < CNT_W'(MAX_LENGTH);

  // Running statistics including the element on the input.
  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (has_room) begin
      if (count_r == '0) begin
        min_nxt = elem;
        max_nxt = elem;
        sum_nxt = elem;
      end else begin
        sum_nxt = sum_r + elem;
        if (elem_less(elem, min_r, type_r[0])) begin
          min_nxt = elem;
        end
        if (elem_less(max_r, elem, type_r[0])) begin
          max_nxt = elem;
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // Request to the divider: all zeros for an empty vector.
  always_comb begin
    if (in_empty_vector) begin
      job_minimum  = '0;
      job_maximum  = '0;
      job_sum      = '0;
      job_count    = '0;
      job_too_long = 1'b0;
    end else begin
      job_minimum  = min_nxt & mask;
      job_maximum  = max_nxt & mask;
      job_sum      = sum_nxt;
      job_count    = count_nxt;
      job_too_long = ovf_nxt;
    end
  end

  // Element type register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= '0;
    end else if (cfg_we) begin
      type_r <= cfg_wdata;
    end
  end

  // Accumulators, cleared when a vector ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (ends_vector) begin
        min_r   <= '0;
        max_r   <= '0;
        sum_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // The count never passes the length limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LENGTH))
    else $error("element count beyond the length limit");

  // Dropped elements are only seen once the vector is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_W'(MAX_LENGTH)))
    else $error("overflow flag set on a vector that is not full");

  // Ending a vector leaves clean accumulators behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> (count_r == '0) && !ovf_r && (sum_r == '0))
    else $error("accumulators not cleared after the end of a vector");

endmodule

FILE: sv/vmm_queue.sv
module vmm_queue import vmm_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);

  localparam int unsigned DEPTH = 2;

  logic [W-1:0] mem_r [DEPTH];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   fill_r;

  assign full     = fill_r == 2'(DEPTH);
  assign valid    = fill_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

FILE: sv/vmm_divider.sv
module vmm_divider import vmm_pkg::*; #(
  parameter int unsigned MEAN_FRACTION_BITS = 16,
  parameter int unsigned CNT_W              = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  output logic                     job_pop,
  input  logic [DATA_W-1:0]        job_minimum,
  input  logic [DATA_W-1:0]        job_maximum,
  input  logic [DATA_W-1:0]        job_sum,
  input  logic [CNT_W-1:0]         job_count,
  input  logic                     job_too_long,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_minimum,
  output logic [DATA_W-1:0]        out_maximum,
  output logic signed [DATA_W-1:0] out_mean_whole,
  output logic [FRAC_W-1:0]        out_mean_fraction,
  output logic [COUNT_W-1:0]       out_element_count,
  output logic                     out_too_long
);

  // The dividend is the magnitude of the sum followed by the fraction bits.
  localparam int unsigned QW = DATA_W + MEAN_FRACTION_BITS;
  localparam int unsigned IW = $clog2(QW + 1);
  localparam logic [QW-1:0] FRAC_MASK = (QW'(1) << MEAN_FRACTION_BITS) - QW'(1);

  div_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  rem_r;
  logic [QW-1:0]     qr_r;
  logic [CNT_W-1:0]  den_r;
  logic              neg_r;
  logic [IW-1:0]     iter_r;
  logic [DATA_W-1:0] min_r;
  logic [DATA_W-1:0] max_r;
  logic              ovf_r;
  logic [DATA_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W-1:0]  rem_step;
  logic [QW-1:0]     qr_step;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] quot;
  logic [QW-1:0]     frac_all;
  logic              load;

  // One restoring division step per cycle.
  assign trial    = {rem_r, qr_r[QW-1]};
  assign fits     = trial >= {1'b0, den_r};
  assign rem_step = fits ? CNT_W'(trial - {1'b0, den_r}) : CNT_W'(trial);
  assign qr_step  = {qr_r[QW-2:0], fits};

  assign mag = job_sum[DATA_W-1] ? (DATA_W'(0) - job_sum) : job_sum;

  // Split the quotient into the whole part and the saturated fraction.
  always_comb begin
    quot      = DATA_W'(qr_r >> MEAN_FRACTION_BITS);
    frac_all  = qr_r & FRAC_MASK;
    whole_nxt = neg_r ? (DATA_W'(0) - quot) : quot;
    frac_nxt  = (|frac_all[31:16]) ? {FRAC_W{1'b1}} : frac_all[15:0];
  end

  // Sequencer: take a request, iterate unless the count is zero, hold the result until taken.
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    out_valid = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      DIV_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          load    = 1'b1;
          state_nxt = (job_count == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (iter_r == '0) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load) begin
      min_r   <= job_minimum;
      max_r   <= job_maximum;
      ovf_r   <= job_too_long;
      den_r   <= job_count;
      neg_r   <= job_sum[DATA_W-1];
      rem_r   <= '0;
      qr_r    <= QW'(mag) << MEAN_FRACTION_BITS;
      iter_r  <= IW'(QW);
      whole_r <= '0;
      frac_r  <= '0;
    end else if (state_r == DIV_RUN) begin
      if (iter_r != '0) begin
        rem_r  <= rem_step;
        qr_r   <= qr_step;
        iter_r <= iter_r - IW'(1);
      end else begin
        whole_r <= whole_nxt;
        frac_r  <= frac_nxt;
      end
    end
  end

  assign out_minimum       = min_r;
  assign out_maximum       = max_r;
  assign out_mean_whole    = whole_r;
  assign out_mean_fraction = frac_r;
  assign out_element_count = COUNT_W'(den_r);
  assign out_too_long      = ovf_r;

  // The partial remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIV_RUN) |-> (rem_r < den_r))
    else $error("partial remainder not below the divisor");

  // A zero count never reaches the iteration.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIV_RUN) |-> (den_r != '0))
    else $error("division started with a zero count");

  // The step counter never exceeds the dividend width.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIV_RUN) |-> (iter_r <= IW'(QW)))
    else $error("division step counter out of range");

endmodule
